// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the root unit and the top module of the constraint violation norms block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CVN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CVN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cvn_pkg.sv =====
// Types and constants of the constraint violation norms block.
package cvn_pkg;

  localparam int unsigned OBJ_W  = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned ROOT_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VIOL,
    S_SQ,
    S_ADD_ALL,
    S_ADD_SEL,
    S_RT_GO,
    S_RT_RUN,
    S_DONE
  } cvn_state_t;

  typedef enum logic [1:0] {
    SEL_EQ,
    SEL_INEQ,
    SEL_ALL
  } cvn_sel_t;

  typedef struct packed {
    logic viol_en;
    logic sq_en;
    logic add_all;
    logic add_sel;
    logic clear;
  } cvn_acc_ctl_t;

endpackage

// ===== rtl/cvn_if.sv =====
// Request channel interfaces of the constraint violation norms block.
interface cvn_in_if import cvn_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic signed [VALUE_WIDTH-1:0] lower_bound;
  logic signed [VALUE_WIDTH-1:0] upper_bound;
  logic                          is_equality;
  logic                          last_item;

  modport source (output valid, value, lower_bound, upper_bound, is_equality, last_item,
                  input ready);
  modport sink (input valid, value, lower_bound, upper_bound, is_equality, last_item,
                output ready);
endinterface

interface cvn_out_if import cvn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OBJ_W-1:0] objective;
  logic [ROOT_W-1:0]       equality_norm;
  logic [ROOT_W-1:0]       inequality_norm;
  logic [ROOT_W-1:0]       overall_norm;
  logic                    saturated;

  modport source (output valid, objective, equality_norm, inequality_norm, overall_norm,
                  saturated, input ready);
  modport sink (input valid, objective, equality_norm, inequality_norm, overall_norm,
                saturated, output ready);
endinterface

// ===== rtl/cvn_accum.sv =====
// Violation, square and saturating accumulation of the three violation sums.
module cvn_accum import cvn_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cvn_acc_ctl_t                  ctl,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic signed [VALUE_WIDTH-1:0] lower_bound,
  input  logic signed [VALUE_WIDTH-1:0] upper_bound,
  input  logic                          is_equality,
  output logic [SUM_W-1:0]              eq_sum,
  output logic [SUM_W-1:0]              ineq_sum,
  output logic [SUM_W-1:0]              all_sum,
  output logic                          ovf
);

  localparam int unsigned EXT_W = VALUE_WIDTH + 1;
  localparam int unsigned SQ_W  = 2 * VALUE_WIDTH;

  logic signed [EXT_W-1:0] v_ext;
  logic signed [EXT_W-1:0] lo_ext;
  logic signed [EXT_W-1:0] hi_ext;
  logic signed [EXT_W-1:0] d_lo;
  logic signed [EXT_W-1:0] d_hi;
  logic [VALUE_WIDTH-1:0]  viol_r;
  logic [VALUE_WIDTH-1:0]  viol_nxt;
  logic [SQ_W-1:0]         sq_r;
  logic [SUM_W-1:0]        sq_ext;
  logic [SUM_W-1:0]        acc_a;
  logic [SUM_W:0]          acc_sum;
  logic [SUM_W-1:0]        acc_res;
  logic [SUM_W-1:0]        eq_r;
  logic [SUM_W-1:0]        ineq_r;
  logic [SUM_W-1:0]        all_r;
  logic                    ovf_r;

  assign v_ext  = EXT_W'(value);
  assign lo_ext = EXT_W'(lower_bound);
  assign hi_ext = EXT_W'(upper_bound);
  assign d_lo   = lo_ext - v_ext;
  assign d_hi   = v_ext - hi_ext;

  always_comb begin
    if (v_ext < lo_ext) begin
      viol_nxt = d_lo[VALUE_WIDTH-1:0];
    end else if (v_ext > hi_ext) begin
      viol_nxt = d_hi[VALUE_WIDTH-1:0];
    end else begin
      viol_nxt = '0;
    end
  end

  // One saturating adder serves the overall sum and then the selected sum.
  assign sq_ext  = SUM_W'(sq_r);
  assign acc_a   = ctl.add_all ? all_r : (is_equality ? eq_r : ineq_r);
  assign acc_sum = {1'b0, acc_a} + {1'b0, sq_ext};
  assign acc_res = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.viol_en) begin
      viol_r <= viol_nxt;
    end
    if (ctl.sq_en) begin
      sq_r <= viol_r * viol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      eq_r   <= '0;
      ineq_r <= '0;
      all_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (ctl.add_all) begin
        all_r <= acc_res;
      end
      if (ctl.add_sel && is_equality) begin
        eq_r <= acc_res;
      end
      if (ctl.add_sel && !is_equality) begin
        ineq_r <= acc_res;
      end
      if ((ctl.add_all || ctl.add_sel) && acc_sum[SUM_W]) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign eq_sum   = eq_r;
  assign ineq_sum = ineq_r;
  assign all_sum  = all_r;
  assign ovf      = ovf_r;

endmodule

// ===== rtl/cvn_isqrt.sv =====
// Bit-serial floor square root of a 64-bit sum, one root bit per cycle.
`include "assert_macros.svh"

module cvn_isqrt import cvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  operand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned SH_W  = REM_W + 2;

  logic [SUM_W-1:0]  x_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [SH_W-1:0]   r_sh;
  logic [SH_W-1:0]   trial;
  logic [SH_W-1:0]   r_diff;
  logic              ge;

  assign r_sh   = {rem_r, x_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, q_r, 2'b01};
  assign ge     = r_sh >= trial;
  assign r_diff = r_sh - trial;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= operand;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[SUM_W-3:0], 2'b00};
      rem_r <= ge ? r_diff[REM_W-1:0] : r_sh[REM_W-1:0];
      q_r   <= {q_r[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = q_r;

  `CVN_ASSERT_NOW(a_start_idle, start, !busy_r)
  `CVN_ASSERT_NOW(a_done_idle, done_r, !busy_r)
  `CVN_ASSERT_NEXT(a_last_step_done, busy_r && !start && cnt_r == '0, done_r)

endmodule

// ===== rtl/constraint_violation_norms.sv =====
// Constraint violation norms: an objective item is only captured; a constraint item goes
// through capture, violation, square, then two passes through one saturating 64-bit
// adder. On the item marked last, one bit-serial root unit produces the equality,
// inequality and overall norms in turn, and then the output register is loaded and its
// request offered. The input is not ready while an item is in work; a finished request
// waits in the output register while the next solution streams in, and the next last
// item waits until it leaves.
`include "assert_macros.svh"

module constraint_violation_norms import cvn_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cvn_in_if.sink     in_ch,
  cvn_out_if.source  out_ch
);

  cvn_state_t              state_r, state_nxt;
  cvn_sel_t                sel_r, sel_nxt;
  cvn_acc_ctl_t            acc_ctl;
  logic                    expecting_r, expecting_nxt;
  logic signed [OBJ_W-1:0] obj_r, obj_nxt;
  logic signed [VALUE_WIDTH-1:0] value_r, lo_r, hi_r;
  logic                    eq_r, last_r;
  logic [ROOT_W-1:0]       eq_root_r, ineq_root_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OBJ_W-1:0] out_obj_r;
  logic [ROOT_W-1:0]       out_eq_r, out_ineq_r, out_all_r;
  logic                    out_sat_r;
  logic                    in_acc;
  logic                    load_out;
  logic                    rt_start;
  logic [SUM_W-1:0]        rt_operand;
  logic                    rt_busy, rt_done;
  logic [ROOT_W-1:0]       rt_root;
  logic [SUM_W-1:0]        eq_sum, ineq_sum, all_sum;
  logic                    ovf;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  cvn_accum #(.VALUE_WIDTH(VALUE_WIDTH)) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .value       (value_r),
    .lower_bound (lo_r),
    .upper_bound (hi_r),
    .is_equality (eq_r),
    .eq_sum      (eq_sum),
    .ineq_sum    (ineq_sum),
    .all_sum     (all_sum),
    .ovf         (ovf)
  );

  always_comb begin
    case (sel_r)
      SEL_EQ:   rt_operand = eq_sum;
      SEL_INEQ: rt_operand = ineq_sum;
      default:  rt_operand = all_sum;
    endcase
  end

  cvn_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rt_start),
    .operand (rt_operand),
    .busy    (rt_busy),
    .done    (rt_done),
    .root    (rt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_EQ;
      expecting_r <= 1'b1;
      obj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      expecting_r <= expecting_nxt;
      obj_r       <= obj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_ch.value;
      lo_r    <= in_ch.lower_bound;
      hi_r    <= in_ch.upper_bound;
      eq_r    <= in_ch.is_equality;
      last_r  <= in_ch.last_item;
    end
    if (rt_done && sel_r == SEL_EQ) begin
      eq_root_r <= rt_root;
    end
    if (rt_done && sel_r == SEL_INEQ) begin
      ineq_root_r <= rt_root;
    end
    if (load_out) begin
      out_obj_r  <= obj_r;
      out_eq_r   <= eq_root_r;
      out_ineq_r <= ineq_root_r;
      out_all_r  <= rt_root;
      out_sat_r  <= ovf;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    expecting_nxt = expecting_r;
    obj_nxt       = obj_r;
    acc_ctl       = '0;
    rt_start      = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (expecting_r) begin
            obj_nxt       = OBJ_W'(in_ch.value);
            expecting_nxt = 1'b0;
            if (in_ch.last_item) begin
              state_nxt = S_RT_GO;
            end
          end else begin
            state_nxt = S_VIOL;
          end
        end
      end
      S_VIOL: begin
        acc_ctl.viol_en = 1'b1;
        state_nxt       = S_SQ;
      end
      S_SQ: begin
        acc_ctl.sq_en = 1'b1;
        state_nxt     = S_ADD_ALL;
      end
      S_ADD_ALL: begin
        acc_ctl.add_all = 1'b1;
        state_nxt       = S_ADD_SEL;
      end
      S_ADD_SEL: begin
        acc_ctl.add_sel = 1'b1;
        state_nxt       = last_r ? S_RT_GO : S_IDLE;
      end
      S_RT_GO: begin
        rt_start  = !rt_busy;
        state_nxt = rt_busy ? S_RT_GO : S_RT_RUN;
      end
      S_RT_RUN: begin
        if (rt_done) begin
          if (sel_r == SEL_ALL) begin
            state_nxt = S_DONE;
          end else begin
            sel_nxt   = (sel_r == SEL_EQ) ? SEL_INEQ : SEL_ALL;
            state_nxt = S_RT_GO;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          acc_ctl.clear = 1'b1;
          expecting_nxt = 1'b1;
          sel_nxt       = SEL_EQ;
          obj_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || load_out;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.objective       = out_obj_r;
  assign out_ch.equality_norm   = out_eq_r;
  assign out_ch.inequality_norm = out_ineq_r;
  assign out_ch.overall_norm    = out_all_r;
  assign out_ch.saturated       = out_sat_r;

  `CVN_ASSERT_NOW(a_root_done_in_run, rt_done, state_r == S_RT_RUN)
  `CVN_ASSERT_NEXT(a_last_leaves_idle, in_acc && in_ch.last_item, state_r != S_IDLE)
  `CVN_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_r && expecting_r && state_r == S_IDLE)

endmodule

// ===== dv/constraint_violation_norms_tb.sv =====
// Self-checking testbench for the constraint violation norms block.
`timescale 1ns / 100ps

module constraint_violation_norms_tb import cvn_pkg::*;;

  localparam int unsigned VALUE_W = 32;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_AT = 25;
  localparam int HOLD_CYCLES = 700;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] lower_bound;
    logic signed [VALUE_W-1:0] upper_bound;
    logic is_equality;
    logic last_item;
  } constraint_item_t;

  typedef struct {
    logic signed [OBJ_W-1:0] objective;
    logic [ROOT_W-1:0] equality_norm;
    logic [ROOT_W-1:0] inequality_norm;
    logic [ROOT_W-1:0] overall_norm;
    logic saturated;
  } norms_t;

  typedef struct {
    constraint_item_t item;
    bit has_want;
    norms_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cvn_in_if #(.VALUE_WIDTH(VALUE_W)) in_ch ();
  cvn_out_if out_ch ();

  constraint_violation_norms #(.VALUE_WIDTH(VALUE_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [OBJ_W-1:0] held_obj;
  logic [SUM_W-1:0] eq_sum;
  logic [SUM_W-1:0] ineq_sum;
  logic [SUM_W-1:0] all_sum;
  bit awaiting_obj;
  bit clamp_seen;

  norms_t pending_norms[$];
  stim_row_t dir_rows[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int solutions_sent = 0;
  int results_taken = 0;
  int results_checked = 0;
  int saturated_seen = 0;
  bit hold_done = 1'b0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  function automatic logic [ROOT_W-1:0] floor_sqrt64(input logic [SUM_W-1:0] x);
    logic [ROOT_W-1:0] r;
    logic [SUM_W-1:0] t;
    r = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      t = {32'd0, r | (32'd1 << i)};
      if (t * t <= x) r = t[ROOT_W-1:0];
    end
    return r;
  endfunction

  task automatic clear_sums();
    held_obj = '0;
    eq_sum = '0;
    ineq_sum = '0;
    all_sum = '0;
    awaiting_obj = 1'b1;
    clamp_seen = 1'b0;
  endtask

  task automatic clamp_add(inout logic [SUM_W-1:0] acc, input logic [SUM_W-1:0] a);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {1'b0, a};
    if (s[SUM_W]) begin
      acc = '1;
      clamp_seen = 1'b1;
    end else begin
      acc = s[SUM_W-1:0];
    end
  endtask

  task automatic accumulate_item(input constraint_item_t it, output bit emits,
                                 output norms_t res);
    longint v, lo, hi, viol;
    logic [SUM_W-1:0] d64;
    logic [SUM_W-1:0] sq;
    v = longint'(it.value);
    lo = longint'(it.lower_bound);
    hi = longint'(it.upper_bound);
    if (awaiting_obj) begin
      held_obj = it.value;
      awaiting_obj = 1'b0;
    end else begin
      viol = 0;
      if (v < lo) viol = lo - v;
      else if (v > hi) viol = v - hi;
      if (viol > longint'(32'hFFFF_FFFF)) begin
        viol = longint'(32'hFFFF_FFFF);
        clamp_seen = 1'b1;
      end
      d64 = viol;
      sq = d64 * d64;
      clamp_add(all_sum, sq);
      if (it.is_equality) clamp_add(eq_sum, sq);
      else clamp_add(ineq_sum, sq);
    end
    emits = it.last_item;
    res.objective = held_obj;
    res.equality_norm = floor_sqrt64(eq_sum);
    res.inequality_norm = floor_sqrt64(ineq_sum);
    res.overall_norm = floor_sqrt64(all_sum);
    res.saturated = clamp_seen;
    if (emits) clear_sums();
  endtask

  task automatic add_item(input logic [31:0] v, input logic [31:0] lo, input logic [31:0] hi,
                          input bit eq, input bit last);
    stim_row_t row;
    row.item = '{v, lo, hi, eq, last};
    row.has_want = 1'b0;
    row.want = '{'0, '0, '0, '0, 1'b0};
    dir_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [31:0] v, input logic [31:0] lo,
                             input logic [31:0] hi, input bit eq,
                             input logic [31:0] obj, input logic [31:0] eqn,
                             input logic [31:0] inn, input logic [31:0] alln,
                             input bit sat);
    stim_row_t row;
    row.item = '{v, lo, hi, eq, 1'b1};
    row.has_want = 1'b1;
    row.want = '{obj, eqn, inn, alln, sat};
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input constraint_item_t it, input bit has_want, input norms_t want);
    int gap;
    bit emits;
    norms_t res;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= it.value;
    in_ch.lower_bound <= it.lower_bound;
    in_ch.upper_bound <= it.upper_bound;
    in_ch.is_equality <= it.is_equality;
    in_ch.last_item <= it.last_item;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_item(it, emits, res);
    if (emits) begin
      pending_norms.push_back(has_want ? want : res);
      solutions_sent++;
    end
    items_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_q();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic send_solution();
    int n;
    constraint_item_t it;
    norms_t none;
    none = '{'0, '0, '0, '0, 1'b0};
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    it = '{pick_q(), $urandom, $urandom, 1'($urandom_range(0, 1)), n == 0};
    send_item(it, 1'b0, none);
    for (int k = 1; k <= n; k++) begin
      it.value = pick_q();
      it.lower_bound = pick_q();
      if ($urandom_range(0, 3) == 0) it.upper_bound = pick_q();
      else it.upper_bound = it.lower_bound + $signed($urandom_range(0, 32'h0004_0000));
      it.is_equality = 1'($urandom_range(0, 1));
      it.last_item = (k == n);
      send_item(it, 1'b0, none);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.lower_bound <= '0;
    in_ch.upper_bound <= '0;
    in_ch.is_equality <= 1'b0;
    in_ch.last_item <= 1'b0;
    clear_sums();

    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    add_checked(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0,
                32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    add_item(32'h0001_0000, 32'hDEAD_BEEF, 32'h1234_5678, 1'b1, 1'b0);
    add_item(32'h0003_0000, 32'h0, 32'h0001_0000, 1'b1, 1'b0);
    add_item(32'hFFFF_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b0);
    add_item(32'h0000_8000, 32'h0, 32'h0001_0000, 1'b0, 1'b0);
    add_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);
    add_item(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0,
                32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_item(32'h1234_5678, 32'h0, 32'h0, 1'b0, 1'b0);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0,
                32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_item(32'h0000_0001, 32'h0, 32'h0, 1'b0, 1'b0);
    add_item(32'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0);
    add_item(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b0);
    add_item(32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b0, 1'b1);
    add_item(32'h0005_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    add_checked(32'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b1,
                32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
    add_checked(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_item(32'h7FFF_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
                32'h7FFF_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!rst_n);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);
    while (items_sent < dir_rows.size() + RANDOM_ITEMS) send_solution();
    in_ch.valid <= 1'b0;

    while (pending_norms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests in %0d solutions; checked %0d norm results, %0d saturated.",
             items_sent, solutions_sent, results_checked, saturated_seen);
    $display("Output hold-off of %0d cycles applied: %0d; mismatches: %0d.",
             HOLD_CYCLES, hold_done, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (results_taken == HOLD_AT && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    norms_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.saturated === 1'b1) saturated_seen++;
      if (pending_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected request at %0t: objective %h norms %h %h %h saturated %b",
                   $realtime, out_ch.objective, out_ch.equality_norm,
                   out_ch.inequality_norm, out_ch.overall_norm, out_ch.saturated);
      end else begin
        want = pending_norms.pop_front();
        results_checked++;
        if (out_ch.objective !== want.objective ||
            out_ch.equality_norm !== want.equality_norm ||
            out_ch.inequality_norm !== want.inequality_norm ||
            out_ch.overall_norm !== want.overall_norm ||
            out_ch.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t on result %0d:", $realtime, results_checked);
            $display("  objective %h/%h eq %h/%h ineq %h/%h overall %h/%h sat %b/%b",
                     want.objective, out_ch.objective, want.equality_norm,
                     out_ch.equality_norm, want.inequality_norm, out_ch.inequality_norm,
                     want.overall_norm, out_ch.overall_norm, want.saturated,
                     out_ch.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                 IDLE_LIMIT, pending_norms.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
